### rtl/bds2x_pkg.sv
// Shared types and constants for the 2x2 box downsampler.
`default_nettype none
package bds2x_pkg;

    localparam int PIX_W     = 8;
    localparam int PAIR_W    = PIX_W + 1;
    localparam int BLOCK_W   = PIX_W + 2;
    localparam int REG_W     = 13;
    localparam int CFG_IDX_W = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Position of one source pixel inside its 2x2 block and the frame.
    typedef struct packed {
        logic odd_col;
        logic last_col;
        logic odd_row;
        logic last_row;
    } bds2x_cls_t;

    localparam int CLS_W = $bits(bds2x_cls_t);

endpackage
`default_nettype wire

### rtl/box_downsample_2x_rgb.sv
// Top level of the 2x2 box-filter RGB downsampler.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------------
//   s_      | in        | s_valid / s_ready | s_red_in, s_green_in, s_blue_in
//   m_      | out       | m_valid / m_ready | m_red_out, m_green_out, m_blue_out,
//           |           |                   | m_row_end, m_frame_end
//   cfg_    | in        | cfg_wr_en         | cfg_index, cfg_wr_data
//
// One source pixel per cycle sustained while m_ready is high; the request that closes
// a block reaches the output through the queue, line store read and output register.
// The line store has one write and one read port; a bottom-row read always
// follows the top-row write of its slot, so no clearing pass is needed after reset.
// A four-entry queue separates counting from the back end, so a stalled output
// backs up into the queue before s_ready drops. Reset is synchronous, active low.
`default_nettype none
module box_downsample_2x_rgb #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bds2x_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bds2x_pkg::REG_W-1:0]     cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [bds2x_pkg::PIX_W-1:0]     s_red_in,
    input  wire logic [bds2x_pkg::PIX_W-1:0]     s_green_in,
    input  wire logic [bds2x_pkg::PIX_W-1:0]     s_blue_in,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bds2x_pkg::PIX_W-1:0]          m_red_out,
    output logic [bds2x_pkg::PIX_W-1:0]          m_green_out,
    output logic [bds2x_pkg::PIX_W-1:0]          m_blue_out,
    output logic                                 m_row_end,
    output logic                                 m_frame_end
);
    import bds2x_pkg::*;

    localparam int DEPTH  = (MAX_WIDTH + 1) / 2;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW     = CLS_W + SLOT_W + 3 * PIX_W;

    logic              q_push, q_full, q_pop, q_not_empty;
    bds2x_cls_t        f_cls, b_cls;
    logic [SLOT_W-1:0] f_slot, b_slot;
    logic [QW-1:0]     q_in, q_out;
    logic [PIX_W-1:0]  b_red, b_green, b_blue;

    bds2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SLOT_W     (SLOT_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cls       (f_cls),
        .q_slot      (f_slot)
    );

    assign q_in = {f_cls, f_slot, s_blue_in, s_green_in, s_red_in};

    bds2x_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    assign {b_cls, b_slot, b_blue, b_green, b_red} = q_out;

    bds2x_back #(
        .DEPTH  (DEPTH),
        .SLOT_W (SLOT_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_not_empty),
        .q_pop       (q_pop),
        .q_cls       (b_cls),
        .q_slot      (b_slot),
        .q_red       (b_red),
        .q_green     (b_green),
        .q_blue      (b_blue),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

endmodule
`default_nettype wire

### rtl/bds2x_front.sv
// Front end: frame registers, raster counters and pixel classification.
`default_nettype none
module bds2x_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int SLOT_W     = 11
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bds2x_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bds2x_pkg::REG_W-1:0]     cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output bds2x_pkg::bds2x_cls_t                q_cls,
    output logic [SLOT_W-1:0]                    q_slot
);
    import bds2x_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW_RAW = $clog2(MAX_DIM + 1);
    localparam int DW = (DW_RAW > REG_W) ? DW_RAW : REG_W;

    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [XW-1:0] w_last_reg, w_last_next;
    logic [YW-1:0] h_last_reg, h_last_next;
    logic          restart;
    logic          last_col, last_row;

    // Zero acts as one, anything above the maximum as the maximum.
    function automatic logic [DW-1:0] clamp_last(input logic [DW-1:0] v,
                                                 input logic [DW-1:0] mx);
        if (v == '0) begin
            return '0;
        end else if (v > mx) begin
            return mx - 1'b1;
        end
        return v - 1'b1;
    endfunction

    assign s_ready  = !q_full;
    assign q_push   = s_valid && s_ready;
    assign last_col = (x_reg == w_last_reg);
    assign last_row = (y_reg == h_last_reg);
    assign restart  = cfg_wr_en &&
                      (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    assign q_cls.odd_col  = x_reg[0];
    assign q_cls.last_col = last_col;
    assign q_cls.odd_row  = y_reg[0];
    assign q_cls.last_row = last_row;
    assign q_slot = SLOT_W'(x_reg >> 1);

    always_comb begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        if (cfg_wr_en && cfg_index == REG_IMAGE_WIDTH) begin
            w_last_next = XW'(clamp_last(DW'(cfg_wr_data), DW'(MAX_WIDTH)));
        end
        if (cfg_wr_en && cfg_index == REG_IMAGE_HEIGHT) begin
            h_last_next = YW'(clamp_last(DW'(cfg_wr_data), DW'(MAX_HEIGHT)));
        end
        if (restart) begin
            x_next = '0;
            y_next = '0;
        end else if (q_push) begin
            if (last_col) begin
                x_next = '0;
                y_next = last_row ? '0 : y_reg + 1'b1;
            end else begin
                x_next = x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg      <= '0;
            y_reg      <= '0;
            w_last_reg <= '0;
            h_last_reg <= '0;
        end else begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
        end
    end

endmodule
`default_nettype wire

### rtl/bds2x_fifo.sv
// Small flop queue between the front end and the back end.
`default_nettype none
module bds2x_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### rtl/bds2x_back.sv
// Back end: pair sums, line store, block average and output register.
`default_nettype none
module bds2x_back #(
    parameter int DEPTH  = 2048,
    parameter int SLOT_W = 11
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    output logic                             q_pop,
    input  wire bds2x_pkg::bds2x_cls_t       q_cls,
    input  wire logic [SLOT_W-1:0]           q_slot,
    input  wire logic [bds2x_pkg::PIX_W-1:0] q_red,
    input  wire logic [bds2x_pkg::PIX_W-1:0] q_green,
    input  wire logic [bds2x_pkg::PIX_W-1:0] q_blue,
    output logic [bds2x_pkg::PIX_W-1:0]      m_red_out,
    output logic [bds2x_pkg::PIX_W-1:0]      m_green_out,
    output logic [bds2x_pkg::PIX_W-1:0]      m_blue_out,
    output logic                             m_row_end,
    output logic                             m_frame_end,
    output logic                             m_valid,
    input  wire logic                        m_ready
);
    import bds2x_pkg::*;

    localparam int ROW_W = 3 * PAIR_W;

    logic [ROW_W-1:0]  row_mem [DEPTH];
    logic [ROW_W-1:0]  rd_data_reg;
    logic [PIX_W-1:0]  pend_r_reg, pend_g_reg, pend_b_reg;

    logic [ROW_W-1:0]  s2_pair_reg;
    logic              s2_valid_reg, s2_valid_next;
    logic              s2_odd_row_reg, s2_row_end_reg, s2_frame_end_reg;
    logic [1:0]        s2_shift_reg;

    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  m_r_reg, m_g_reg, m_b_reg;
    logic              m_row_end_reg, m_frame_end_reg;

    logic              closes_pair, produce, store_wr, store_rd, s2_adv;
    logic [PAIR_W-1:0] pair_r, pair_g, pair_b;
    logic [ROW_W-1:0]  pair, above;
    logic [BLOCK_W-1:0] sum_r, sum_g, sum_b;

    assign closes_pair = q_cls.odd_col || q_cls.last_col;
    assign produce     = closes_pair && (q_cls.odd_row || q_cls.last_row);
    assign store_wr    = q_pop && closes_pair && !q_cls.odd_row && !q_cls.last_row;
    assign store_rd    = q_pop && produce && q_cls.odd_row;

    assign s2_adv = s2_valid_reg && (!m_valid_reg || m_ready);
    assign q_pop  = q_valid && (!s2_valid_reg || s2_adv);

    // Horizontal pair: odd column adds the held even pixel, a lone last column stands alone.
    always_comb begin
        pair_r = {1'b0, q_red};
        pair_g = {1'b0, q_green};
        pair_b = {1'b0, q_blue};
        if (q_cls.odd_col) begin
            pair_r = {1'b0, q_red}   + {1'b0, pend_r_reg};
            pair_g = {1'b0, q_green} + {1'b0, pend_g_reg};
            pair_b = {1'b0, q_blue}  + {1'b0, pend_b_reg};
        end
    end
    assign pair = {pair_b, pair_g, pair_r};

    always_ff @(posedge aclk) begin
        if (q_pop && !closes_pair) begin
            pend_r_reg <= q_red;
            pend_g_reg <= q_green;
            pend_b_reg <= q_blue;
        end
        if (store_wr) begin
            row_mem[q_slot] <= pair;
        end
        if (store_rd) begin
            rd_data_reg <= row_mem[q_slot];
        end
    end

    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (q_pop) begin
            s2_valid_next = produce;
        end else if (s2_adv) begin
            s2_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s2_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s2_pair_reg      <= pair;
            s2_odd_row_reg   <= q_cls.odd_row;
            s2_shift_reg     <= {1'b0, q_cls.odd_col} + {1'b0, q_cls.odd_row};
            s2_row_end_reg   <= q_cls.last_col;
            s2_frame_end_reg <= q_cls.last_col && q_cls.last_row;
        end
    end

    // Bottom row adds the stored top-row pair; a lone last row adds nothing.
    assign above = s2_odd_row_reg ? rd_data_reg : '0;
    assign sum_r = {1'b0, s2_pair_reg[PAIR_W-1:0]} + {1'b0, above[PAIR_W-1:0]};
    assign sum_g = {1'b0, s2_pair_reg[2*PAIR_W-1:PAIR_W]}
                 + {1'b0, above[2*PAIR_W-1:PAIR_W]};
    assign sum_b = {1'b0, s2_pair_reg[3*PAIR_W-1:2*PAIR_W]}
                 + {1'b0, above[3*PAIR_W-1:2*PAIR_W]};

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_r_reg         <= PIX_W'(sum_r >> s2_shift_reg);
            m_g_reg         <= PIX_W'(sum_g >> s2_shift_reg);
            m_b_reg         <= PIX_W'(sum_b >> s2_shift_reg);
            m_row_end_reg   <= s2_row_end_reg;
            m_frame_end_reg <= s2_frame_end_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_r_reg;
    assign m_green_out = m_g_reg;
    assign m_blue_out  = m_b_reg;
    assign m_row_end   = m_row_end_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule
`default_nettype wire

### rtl/bds2x_checker.sv
// Port-level checks for the downsampler, bound to the top level.
`default_nettype none
module bds2x_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic [bds2x_pkg::PIX_W-1:0]     s_red_in,
    input wire logic [bds2x_pkg::PIX_W-1:0]     s_green_in,
    input wire logic [bds2x_pkg::PIX_W-1:0]     s_blue_in,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [bds2x_pkg::PIX_W-1:0]     m_red_out,
    input wire logic [bds2x_pkg::PIX_W-1:0]     m_green_out,
    input wire logic [bds2x_pkg::PIX_W-1:0]     m_blue_out,
    input wire logic                            m_row_end,
    input wire logic                            m_frame_end
);
    import bds2x_pkg::*;

    // Hold a stalled request.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_red_in) && $stable(s_green_in)
            && $stable(s_blue_in))
        else $error("stalled request changed");

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out) && $stable(m_green_out)
            && $stable(m_blue_out) && $stable(m_row_end) && $stable(m_frame_end))
        else $error("stalled result changed");

    // The last block of a frame also closes its row.
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_frame_end || m_row_end))
        else $error("frame end without row end");

    // Drop any result in flight on reset.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind box_downsample_2x_rgb bds2x_checker u_bds2x_checker (.*);
`default_nettype wire
